// ===== rtl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master: command codes,
// register indexes, register reset values and the bus phase encoding.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int TIMER_BITS_DEF = 10;
	localparam int CFG_DATA_W     = 10;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [1:0] {
		FUNC_NONE  = 2'd0,
		FUNC_RESET = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
	localparam cfg_idx_t CFG_PRESENCE_WAIT = 3'd1;
	localparam cfg_idx_t CFG_PRESENCE_HOLD = 3'd2;
	localparam cfg_idx_t CFG_SLOT_HOLD     = 3'd3;
	localparam cfg_idx_t CFG_SLOT_LOW      = 3'd4;
	localparam cfg_idx_t CFG_SAMPLE_DELAY  = 3'd5;
	localparam cfg_idx_t CFG_RECOVERY      = 3'd6;

	localparam logic [9:0] RST_RESET_LOW     = 10'd480;
	localparam logic [9:0] RST_PRESENCE_WAIT = 10'd150;
	localparam logic [9:0] RST_PRESENCE_HOLD = 10'd330;
	localparam logic [7:0] RST_SLOT_HOLD     = 8'd60;
	localparam logic [3:0] RST_SLOT_LOW      = 4'd6;
	localparam logic [3:0] RST_SAMPLE_DELAY  = 4'd0;
	localparam logic [5:0] RST_RECOVERY      = 6'd6;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [8:0] {
		PH_IDLE        = 9'b000000001,
		PH_RST_LOW     = 9'b000000010,
		PH_RST_WAIT    = 9'b000000100,
		PH_RST_WATCH   = 9'b000001000,
		PH_RST_HOLD    = 9'b000010000,
		PH_SLOT_LOW    = 9'b000100000,
		PH_SLOT_SAMPLE = 9'b001000000,
		PH_SLOT_HOLD   = 9'b010000000,
		PH_SLOT_REC    = 9'b100000000
	} phase_t;

endpackage

// ===== rtl/owbm_req_if.sv =====
// ----------------------------------------------------------------------------
// owbm_req_if
// Request channel: one bus clock of command, byte, line level and tick.
// ----------------------------------------------------------------------------
interface owbm_req_if;
	logic                  valid;
	logic                  ready;
	owbm_pkg::func_t       func;
	logic [7:0]            tx_byte;
	logic                  final_byte;
	logic                  bus_level;
	logic                  us_tick;

	modport source (output valid, func, tx_byte, final_byte, bus_level, us_tick,
		input ready);
	modport sink (input valid, func, tx_byte, final_byte, bus_level, us_tick,
		output ready);
endinterface

// ===== rtl/owbm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// owbm_rsp_if
// Result channel: line drive, busy and completion pulses per request.
// ----------------------------------------------------------------------------
interface owbm_rsp_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic [7:0] rx_byte;
	logic       byte_done;
	logic       transfer_end;
	logic       reset_done;

	modport source (output valid, drive_low, busy_res, rx_byte, byte_done,
		transfer_end, reset_done, input ready);
	modport sink (input valid, drive_low, busy_res, rx_byte, byte_done,
		transfer_end, reset_done, output ready);
endinterface

// ===== rtl/owbm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface owbm_cfg_if;
	logic                 valid;
	logic                 ready;
	owbm_pkg::cfg_idx_t   index;
	owbm_pkg::cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-master 1-Wire bus controller: bus reset, write byte and read byte
// sequences timed by microsecond ticks, one request per clock unless rsp stalls.
// ----------------------------------------------------------------------------
// Result: the result of a request is in the output register from the cycle after
// the request is accepted.
// Throughput: one request per cycle; the output register is refilled in the
// cycle it is taken, so input and output only stall on output backpressure.
// Reset: arst_n clears the phase to idle, counters and shift data to zero and
// loads the timing registers with their defaults; no clearing pass is needed.
module one_wire_bus_master #(
	parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	owbm_req_if.sink   req,
	owbm_rsp_if.source rsp,
	owbm_cfg_if.sink   cfg
);
	import owbm_pkg::*;

	localparam int CW = (TIMER_BITS > 10) ? TIMER_BITS : 10;
	localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

	// timing registers
	logic [9:0] reset_low_q, presence_wait_q, presence_hold_q;
	logic [7:0] slot_hold_q;
	logic [3:0] slot_low_q, sample_delay_q;
	logic [5:0] recovery_q;

	// sequencer state
	phase_t                phase_q, phase_n;
	logic [TIMER_BITS-1:0] cnt_q, cnt_n, cnt_inc, tgt;
	logic [CW-1:0]         tgt_raw;
	logic [2:0]            bit_q, bit_n;
	logic [7:0]            shift_q, shift_n;
	logic                  is_read_q, is_read_n;
	logic                  last_q, last_n;
	logic                  tmr_done;

	// result register
	logic       rsp_valid_q;
	logic       drive_q, busy_q, done_q, tend_q, rdone_q;
	logic [7:0] rx_q;
	logic       drive_n, done_n, tend_n, rdone_n;
	logic [7:0] rx_n;

	logic in_ready, accept;

	assign in_ready  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && in_ready;
	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	// target of the current timed phase, clipped to the counter range
	always_comb begin
		case (phase_q)
			PH_RST_LOW:     tgt_raw = CW'(reset_low_q);
			PH_RST_WAIT:    tgt_raw = CW'(presence_wait_q);
			PH_RST_HOLD:    tgt_raw = CW'(presence_hold_q);
			PH_SLOT_LOW:    tgt_raw = CW'(slot_low_q);
			PH_SLOT_SAMPLE: tgt_raw = CW'(sample_delay_q);
			PH_SLOT_HOLD:   tgt_raw = CW'(slot_hold_q);
			PH_SLOT_REC:    tgt_raw = CW'(recovery_q);
			default:        tgt_raw = '0;
		endcase
	end

	assign tgt      = (tgt_raw > CNT_MAX) ? CNT_MAX[TIMER_BITS-1:0] : tgt_raw[TIMER_BITS-1:0];
	assign tmr_done = (cnt_q >= tgt);
	assign cnt_inc  = (req.us_tick && (cnt_q != CNT_MAX[TIMER_BITS-1:0])) ?
		cnt_q + 1'b1 : cnt_q;

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = tmr_done ? '0 : cnt_inc;
		bit_n     = bit_q;
		shift_n   = shift_q;
		is_read_n = is_read_q;
		last_n    = last_q;
		done_n    = 1'b0;
		tend_n    = 1'b0;
		rdone_n   = 1'b0;
		rx_n      = 8'd0;
		case (phase_q)
			PH_IDLE: begin
				cnt_n = '0;
				if (req.func == FUNC_RESET) begin
					phase_n = PH_RST_LOW;
				end else if (req.func == FUNC_WRITE || req.func == FUNC_READ) begin
					is_read_n = (req.func == FUNC_READ);
					shift_n   = (req.func == FUNC_READ) ? 8'd0 : req.tx_byte;
					last_n    = req.final_byte;
					bit_n     = 3'd0;
					phase_n   = PH_SLOT_LOW;
				end
			end
			PH_RST_LOW: begin
				if (tmr_done) phase_n = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (tmr_done) phase_n = PH_RST_WATCH;
			end
			PH_RST_WATCH: begin
				// wait for the line to come back high, without limit
				cnt_n = '0;
				if (req.bus_level) phase_n = PH_RST_HOLD;
			end
			PH_RST_HOLD: begin
				if (tmr_done) begin
					phase_n = PH_IDLE;
					rdone_n = 1'b1;
				end
			end
			PH_SLOT_LOW: begin
				if (tmr_done) phase_n = is_read_q ? PH_SLOT_SAMPLE : PH_SLOT_HOLD;
			end
			PH_SLOT_SAMPLE: begin
				if (tmr_done) begin
					shift_n = {req.bus_level, shift_q[7:1]};
					phase_n = PH_SLOT_HOLD;
				end
			end
			PH_SLOT_HOLD: begin
				if (tmr_done) phase_n = PH_SLOT_REC;
			end
			PH_SLOT_REC: begin
				if (tmr_done) begin
					// advance to the next bit of a write byte
					if (!is_read_q) shift_n = {1'b0, shift_q[7:1]};
					if (bit_q == LAST_BIT) begin
						bit_n   = 3'd0;
						phase_n = PH_IDLE;
						done_n  = 1'b1;
						tend_n  = last_q;
						rx_n    = is_read_q ? shift_q : 8'd0;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_SLOT_LOW;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	assign drive_n = (phase_n == PH_RST_LOW) || (phase_n == PH_SLOT_LOW) ||
		((phase_n == PH_SLOT_HOLD) && !is_read_n && !shift_n[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= RST_RESET_LOW;
			presence_wait_q <= RST_PRESENCE_WAIT;
			presence_hold_q <= RST_PRESENCE_HOLD;
			slot_hold_q     <= RST_SLOT_HOLD;
			slot_low_q      <= RST_SLOT_LOW;
			sample_delay_q  <= RST_SAMPLE_DELAY;
			recovery_q      <= RST_RECOVERY;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_RESET_LOW:     reset_low_q     <= cfg.data[9:0];
				CFG_PRESENCE_WAIT: presence_wait_q <= cfg.data[9:0];
				CFG_PRESENCE_HOLD: presence_hold_q <= cfg.data[9:0];
				CFG_SLOT_HOLD:     slot_hold_q     <= cfg.data[7:0];
				CFG_SLOT_LOW:      slot_low_q      <= cfg.data[3:0];
				CFG_SAMPLE_DELAY:  sample_delay_q  <= cfg.data[3:0];
				CFG_RECOVERY:      recovery_q      <= cfg.data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			bit_q     <= 3'd0;
			shift_q   <= 8'd0;
			is_read_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			bit_q     <= bit_n;
			shift_q   <= shift_n;
			is_read_q <= is_read_n;
			last_q    <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (in_ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			drive_q <= drive_n;
			busy_q  <= (phase_n != PH_IDLE);
			rx_q    <= rx_n;
			done_q  <= done_n;
			tend_q  <= tend_n;
			rdone_q <= rdone_n;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.drive_low    = drive_q;
	assign rsp.busy_res     = busy_q;
	assign rsp.rx_byte      = rx_q;
	assign rsp.byte_done    = done_q;
	assign rsp.transfer_end = tend_q;
	assign rsp.reset_done   = rdone_q;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q)) else $error("phase register not one-hot");

	a_tend_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && tend_q |-> done_q) else $error("transfer_end without byte_done");

	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(done_q && rdone_q)) else $error("byte and reset done together");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (done_q || rdone_q) |-> !busy_q) else $error("busy after completion");

	a_rx_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rx_q != 8'd0) |-> done_q) else $error("rx_byte outside byte_done");

endmodule
